// ----- hdl/frse_pkg.sv -----
// ----------------------------------------------------------------------------
// frse_pkg: shared types and constants for the striped extent mapper
// Holds the arithmetic unit request type, status codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package frse_pkg;

	typedef enum logic {
		OP_DIV,
		OP_MUL
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quo;
		logic [31:0] rem;
	} alu_rsp_t;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_ZERO_LEN   = 2'd1;
	localparam logic [1:0] ST_BAD_LAYOUT = 2'd2;

	localparam logic [1:0] REG_OBJECT = 2'd0;
	localparam logic [1:0] REG_UNIT   = 2'd1;
	localparam logic [1:0] REG_WIDTH  = 2'd2;

	localparam logic [31:0] OBJECT_RESET = 32'd4194304;
	localparam logic [31:0] UNIT_RESET   = 32'd4194304;
	localparam logic [31:0] WIDTH_RESET  = 32'd1;

endpackage

`default_nettype wire

// ----- hdl/file_range_to_striped_extents.sv -----
// ----------------------------------------------------------------------------
// file_range_to_striped_extents: file byte range to striped object extents
// Splits a range into one piece per stripe unit under a striped layout.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  cfg     | in        | cfg_we               | cfg_index, cfg_data
//  in      | in        | in_valid / in_ready  | range_start, range_length,
//          |           |                      | file_trunc, buf_base
//  out     | out       | out_valid / out_ready| obj_number .. last
//
//  Setup: 7 divides and 2 multiplies on the shared unit, then 3 divides and
//  2 multiplies to place the first piece. A divide or a multiply holds the
//  sequencer from issue until the unit reports done. Each further piece then
//  passes through PREP and FORM once the previous piece is taken; a piece
//  that wraps the 64-bit offset redoes the placement first.
//  Error results are valid in the cycle after acceptance.
//  in_ready is high only when idle. Reset clears control state and loads the
//  configuration reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module file_range_to_striped_extents
	import frse_pkg::*;
#(
	parameter int MAX_PIECES = 64
)
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [63:0] range_start,
	input  wire logic [63:0] range_length,
	input  wire logic [63:0] file_trunc,
	input  wire logic [63:0] buf_base,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      obj_number,
	output logic [31:0]      obj_offset,
	output logic [31:0]      piece_length,
	output logic [63:0]      buf_offset,
	output logic [63:0]      obj_trunc,
	output logic [1:0]       status,
	output logic             range_cut,
	output logic             last
);

	localparam int CW = $clog2(MAX_PIECES + 1);
	localparam logic [CW-1:0] CNT_LAST = CW'(MAX_PIECES - 1);

	typedef enum logic [2:0] {
		IDLE, ISSUE, WAIT, PREP, FORM, OUT
	} state_t;

	typedef enum logic [3:0] {
		S_SPOM, S_SPOT, S_TOS, S_TSET, S_TBLK, S_TSTR, S_TSR, S_TOBJ, S_TLO,
		S_BLK, S_STR, S_Q, S_OBJB, S_OOFB
	} step_t;

	state_t state_q;
	step_t  step_q;

	logic [31:0] os_q, su_q, sc_q;
	logic [31:0] sum_q, spom_q, spot_q;
	logic [63:0] cur_q, left_q, trunc_q, boff_q;
	logic [63:0] tmp_q, tset_q, tobj_q, tlo_q, q_q, objb_q;
	logic [31:0] trem_q, tpos_q, tsr_q, inunit_q, pos_q, sr_q, ooffb_q;
	logic [CW-1:0] cnt_q;
	logic [63:0] objno_q, rest_q;
	logic [31:0] plen_q, ooff_q;

	logic [63:0] objno_r, ooff_r, ptrunc_r, boff_r;
	logic [31:0] plen_r, ooff32_r;
	logic [1:0]  status_r;
	logic        cut_r, last_r, valid_q;

	alu_req_t    req;
	alu_rsp_t    rsp;
	logic [63:0] alu_a;
	logic [31:0] alu_b;

	logic        bad_cfg;
	logic [31:0] room;
	logic [31:0] plen_n;
	logic        fin;
	logic [63:0] trunc_n;
	logic [64:0] cur_sum;

	frse_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.a      (alu_a),
		.b      (alu_b),
		.rsp    (rsp)
	);

	always_comb begin
		req.start = (state_q == ISSUE);
		req.op    = OP_DIV;
		alu_a     = cur_q;
		alu_b     = sum_q;
		case (step_q)
			S_SPOM: begin alu_a = {32'd0, os_q}; alu_b = sum_q; end
			S_SPOT: begin alu_a = {32'd0, os_q}; alu_b = su_q; end
			S_TOS:  begin alu_a = trunc_q; alu_b = os_q; end
			S_TSET: begin alu_a = tmp_q; alu_b = sc_q; end
			S_TBLK: begin alu_a = trunc_q; alu_b = su_q; end
			S_TSTR: begin alu_a = tmp_q; alu_b = sc_q; end
			S_TSR:  begin alu_a = tmp_q; alu_b = spot_q; end
			S_TOBJ: begin req.op = OP_MUL; alu_a = tset_q; alu_b = sc_q; end
			S_TLO:  begin req.op = OP_MUL; alu_a = {32'd0, tsr_q}; alu_b = su_q; end
			S_BLK:  begin alu_a = cur_q; alu_b = sum_q; end
			S_STR:  begin alu_a = tmp_q; alu_b = sc_q; end
			S_Q:    begin alu_a = tmp_q; alu_b = spom_q; end
			S_OBJB: begin req.op = OP_MUL; alu_a = q_q; alu_b = sc_q; end
			S_OOFB: begin req.op = OP_MUL; alu_a = {32'd0, sr_q}; alu_b = sum_q; end
			default: begin alu_a = cur_q; alu_b = sum_q; end
		endcase
	end

	always_comb begin
		bad_cfg = (os_q == 32'd0) || (su_q == 32'd0) || (sc_q == 32'd0) || (su_q > os_q);
		room    = sum_q - inunit_q;
		plen_n  = (left_q > {32'd0, room}) ? room : left_q[31:0];
		fin     = (rest_q == 64'd0) || (cnt_q == CNT_LAST);
		if (trunc_q == 64'd0 || trunc_q == '1) begin
			trunc_n = trunc_q;
		end else if (q_q > tset_q) begin
			trunc_n = 64'd0;
		end else if (q_q < tset_q) begin
			trunc_n = {32'd0, os_q};
		end else if (objno_q < tobj_q) begin
			trunc_n = tlo_q + {32'd0, su_q};
		end else if (objno_q > tobj_q) begin
			trunc_n = tlo_q;
		end else begin
			trunc_n = tlo_q + {32'd0, trem_q};
		end
		cur_sum = {1'b0, cur_q} + {33'd0, plen_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			step_q  <= S_SPOM;
			valid_q <= 1'b0;
			os_q    <= OBJECT_RESET;
			su_q    <= UNIT_RESET;
			sc_q    <= WIDTH_RESET;
			cnt_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_OBJECT: os_q <= cfg_data;
					REG_UNIT:   su_q <= cfg_data;
					REG_WIDTH:  sc_q <= cfg_data;
					default:    os_q <= os_q;
				endcase
			end
			case (state_q)
				IDLE: begin
					if (in_valid) begin
						cur_q   <= range_start;
						left_q  <= range_length;
						trunc_q <= file_trunc;
						boff_q  <= buf_base;
						cnt_q   <= '0;
						sum_q   <= (sc_q == 32'd1) ? os_q : su_q;
						objno_r <= '0;
						ooff32_r <= '0;
						plen_r  <= '0;
						boff_r  <= '0;
						ptrunc_r <= '0;
						cut_r   <= 1'b0;
						last_r  <= 1'b1;
						if (range_length == 64'd0) begin
							status_r <= ST_ZERO_LEN;
							valid_q  <= 1'b1;
							state_q  <= OUT;
						end else if (bad_cfg) begin
							status_r <= ST_BAD_LAYOUT;
							valid_q  <= 1'b1;
							state_q  <= OUT;
						end else begin
							status_r <= ST_OK;
							step_q   <= S_SPOM;
							state_q  <= ISSUE;
						end
					end
				end
				ISSUE: begin
					state_q <= WAIT;
				end
				WAIT: begin
					if (rsp.done) begin
						state_q <= ISSUE;
						case (step_q)
							S_SPOM: begin spom_q <= rsp.quo[31:0]; step_q <= S_SPOT; end
							S_SPOT: begin spot_q <= rsp.quo[31:0]; step_q <= S_TOS; end
							S_TOS:  begin tmp_q <= rsp.quo; step_q <= S_TSET; end
							S_TSET: begin tset_q <= rsp.quo; step_q <= S_TBLK; end
							S_TBLK: begin
								tmp_q  <= rsp.quo;
								trem_q <= rsp.rem;
								step_q <= S_TSTR;
							end
							S_TSTR: begin
								tmp_q  <= rsp.quo;
								tpos_q <= rsp.rem;
								step_q <= S_TSR;
							end
							S_TSR:  begin tsr_q <= rsp.rem; step_q <= S_TOBJ; end
							S_TOBJ: begin
								tobj_q <= rsp.quo + {32'd0, tpos_q};
								step_q <= S_TLO;
							end
							S_TLO:  begin tlo_q <= rsp.quo; step_q <= S_BLK; end
							S_BLK: begin
								tmp_q    <= rsp.quo;
								inunit_q <= rsp.rem;
								step_q   <= S_STR;
							end
							S_STR: begin
								tmp_q  <= rsp.quo;
								pos_q  <= rsp.rem;
								step_q <= S_Q;
							end
							S_Q: begin
								q_q    <= rsp.quo;
								sr_q   <= rsp.rem;
								step_q <= S_OBJB;
							end
							S_OBJB: begin objb_q <= rsp.quo; step_q <= S_OOFB; end
							S_OOFB: begin
								ooffb_q <= rsp.quo[31:0];
								state_q <= PREP;
							end
							default: state_q <= IDLE;
						endcase
					end
				end
				PREP: begin
					objno_q <= objb_q + {32'd0, pos_q};
					plen_q  <= plen_n;
					ooff_q  <= ooffb_q + inunit_q;
					rest_q  <= left_q - {32'd0, plen_n};
					state_q <= FORM;
				end
				FORM: begin
					objno_r  <= objno_q;
					ooff32_r <= ooff_q;
					plen_r   <= plen_q;
					boff_r   <= boff_q;
					ptrunc_r <= trunc_n;
					status_r <= ST_OK;
					last_r   <= fin;
					cut_r    <= fin && (rest_q != 64'd0);
					valid_q  <= 1'b1;
					state_q  <= OUT;
				end
				OUT: begin
					if (out_ready) begin
						valid_q <= 1'b0;
						if (last_r) begin
							state_q <= IDLE;
						end else begin
							left_q   <= rest_q;
							cur_q    <= cur_sum[63:0];
							boff_q   <= boff_q + {32'd0, plen_q};
							cnt_q    <= cnt_q + CW'(1);
							inunit_q <= '0;
							if (cur_sum[64]) begin
								// offset wrapped: place the next piece from scratch
								step_q  <= S_BLK;
								state_q <= ISSUE;
							end else begin
								state_q <= PREP;
								if (pos_q + 32'd1 == sc_q) begin
									pos_q <= '0;
									if (sr_q + 32'd1 == spom_q) begin
										sr_q    <= '0;
										ooffb_q <= '0;
										q_q     <= q_q + 64'd1;
										objb_q  <= objb_q + {32'd0, sc_q};
									end else begin
										sr_q    <= sr_q + 32'd1;
										ooffb_q <= ooffb_q + sum_q;
									end
								end else begin
									pos_q <= pos_q + 32'd1;
								end
							end
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign ooff_r       = {32'd0, ooff32_r};
	assign in_ready     = (state_q == IDLE);
	assign out_valid    = valid_q;
	assign obj_number   = objno_r;
	assign obj_offset   = ooff_r[31:0];
	assign piece_length = plen_r;
	assign buf_offset   = boff_r;
	assign obj_trunc    = ptrunc_r;
	assign status       = status_r;
	assign range_cut    = cut_r;
	assign last         = last_r;

endmodule

`default_nettype wire

// ----- hdl/frse_alu.sv -----
// ----------------------------------------------------------------------------
// frse_alu: shared iterative divide / multiply unit
// 64/32 restoring divide, one quotient bit a cycle, and a 64x32 shift-add
// multiply modulo 2^64, one partial product a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module frse_alu
	import frse_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire alu_req_t    req,
	input  wire logic [63:0] a,
	input  wire logic [31:0] b,
	output alu_rsp_t         rsp
);

	logic        busy_q;
	logic        done_q;
	alu_op_t     op_q;
	logic [6:0]  cnt_q;
	logic [63:0] acc_q;
	logic [31:0] rem_q;
	logic [63:0] mcand_q;
	logic [31:0] b_q;

	logic [32:0] trial;
	logic [32:0] diff;
	logic        fits;

	always_comb begin
		trial = {rem_q, acc_q[63]};
		diff  = trial - {1'b0, b_q};
		fits  = (trial >= {1'b0, b_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_DIV;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				b_q    <= b;
				if (req.op == OP_DIV) begin
					acc_q <= a;
					rem_q <= '0;
					cnt_q <= 7'd64;
				end else begin
					acc_q   <= '0;
					mcand_q <= a;
					cnt_q   <= 7'd32;
				end
			end else if (busy_q) begin
				case (op_q)
					OP_DIV: begin
						rem_q <= fits ? diff[31:0] : trial[31:0];
						acc_q <= {acc_q[62:0], fits};
					end
					OP_MUL: begin
						if (b_q[0]) begin
							acc_q <= acc_q + mcand_q;
						end
						mcand_q <= {mcand_q[62:0], 1'b0};
						b_q     <= {1'b0, b_q[31:1]};
					end
					default: begin
						acc_q <= acc_q;
					end
				endcase
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = acc_q;
	assign rsp.rem  = rem_q;

endmodule

`default_nettype wire

// ----- hdl/frse_chk.sv -----
// ----------------------------------------------------------------------------
// frse_chk: port-level checks for the striped extent mapper
// Watches the result channel and the input handshake over time.
// ----------------------------------------------------------------------------
`default_nettype none

module frse_chk
	import frse_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [63:0] obj_number,
	input wire logic [1:0]  status,
	input wire logic        range_cut,
	input wire logic        last
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(obj_number) && $stable(last))
		else $error("stalled result changed");

	// no new transaction while a result is pending
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while result pending");

	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> last && !range_cut && obj_number == 64'd0)
		else $error("error result malformed");

	a_cut: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_cut |-> last)
		else $error("cut on a non-final result");

endmodule

bind file_range_to_striped_extents frse_chk u_frse_chk (.*);

`default_nettype wire
